[design/fssa_pkg.sv]
// Package for the frame-stamped slot allocator.
// Holds request/response structs, state enum and shared constants; no dependencies.
package fssa_pkg;

  localparam int unsigned SlotCountDef = 8;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned FrameW       = 32;
  localparam int unsigned SlotIdxW     = 3;

  typedef struct packed {
    logic [KeyW-1:0]   light_id;
    logic [FrameW-1:0] frame_now;
  } fssa_req_t;

  typedef struct packed {
    logic                found;
    logic [SlotIdxW-1:0] slot_index;
    logic                reject_history;
  } fssa_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } fssa_state_e;

endpackage

[design/frame_stamped_slot_allocator.sv]
// Sequence: accept, then a scan that reads the table one slot a cycle and stops at the first empty or
// matching slot or at the last slot, then an update that commits the result once the output is free.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: all slots empty (valid bits cleared), sequencer idle, no response pending.
// Key and frame tables are memories that are not reset; empty slots ignore them.
// Depends on fssa_pkg.
module frame_stamped_slot_allocator #(
  parameter int unsigned SLOT_COUNT = fssa_pkg::SlotCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  fssa_pkg::fssa_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output fssa_pkg::fssa_rsp_t rsp_o
);
  import fssa_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  fssa_state_e state_q, state_d;

  logic [KeyW-1:0]   key_mem   [SLOT_COUNT];
  logic [FrameW-1:0] frame_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid_q;

  logic [KeyW-1:0]   key_q;
  logic [FrameW-1:0] now_q;
  logic [KeyW-1:0]   key_rd_q;
  logic [FrameW-1:0] frame_rd_q;

  logic [CntW-1:0]   cnt_q;
  logic              eval_vld_q;
  logic [IdxW-1:0]   eval_idx_q;
  logic              have_old_q;
  logic [IdxW-1:0]   old_idx_q;
  logic [FrameW-1:0] old_frame_q;

  logic              found_q;
  logic [IdxW-1:0]   pick_q;
  logic              rej_q;

  logic              rsp_valid_q;
  fssa_rsp_t         rsp_q;

  logic              accept;
  logic              issue_rd;
  logic              out_free;
  logic              commit;

  logic              cur_valid;
  logic              key_eq;
  logic              hit_keep;
  logic              hit_take;
  logic              is_older;
  logic              have_old_nx;
  logic [IdxW-1:0]   old_idx_nx;
  logic [FrameW-1:0] old_frame_nx;
  logic              last_slot;
  logic              scan_done;
  logic [FrameW-1:0] prev_frame;
  logic [31:0]       pick_ext;

  assign out_free = !rsp_valid_q || !rsp_stall_i;
  assign prev_frame = now_q - FrameW'(1);

  // per-slot evaluation on the registered table read
  always_comb begin
    cur_valid    = slot_valid_q[eval_idx_q];
    key_eq       = (key_rd_q == key_q);
    hit_keep     = cur_valid && key_eq && (frame_rd_q == prev_frame);
    hit_take     = !cur_valid || key_eq;
    is_older     = (frame_rd_q < now_q) && (!have_old_q || (frame_rd_q < old_frame_q));
    have_old_nx  = have_old_q;
    old_idx_nx   = old_idx_q;
    old_frame_nx = old_frame_q;
    if (is_older) begin
      have_old_nx  = 1'b1;
      old_idx_nx   = eval_idx_q;
      old_frame_nx = frame_rd_q;
    end
    last_slot = (eval_idx_q == IdxW'(SLOT_COUNT - 1));
    scan_done = eval_vld_q && (hit_keep || hit_take || last_slot);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall_o = 1'b1;
    accept      = 1'b0;
    issue_rd    = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_stall_o = 1'b0;
        accept      = req_valid_i;
      end
      ST_SCAN: begin
        issue_rd = (cnt_q < CntW'(SLOT_COUNT));
      end
      ST_UPDATE: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slot tables
  always_ff @(posedge clk_i) begin
    if (commit && found_q) begin
      key_mem[pick_q]   <= key_q;
      frame_mem[pick_q] <= now_q;
    end
    key_rd_q   <= key_mem[cnt_q[IdxW-1:0]];
    frame_rd_q <= frame_mem[cnt_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (commit && found_q) begin
      slot_valid_q[pick_q] <= 1'b1;
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      eval_vld_q <= 1'b0;
      eval_idx_q <= '0;
      have_old_q <= 1'b0;
    end else if (accept) begin
      cnt_q      <= '0;
      eval_vld_q <= 1'b0;
      have_old_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (issue_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      eval_vld_q <= issue_rd && !scan_done;
      eval_idx_q <= cnt_q[IdxW-1:0];
      if (eval_vld_q) begin
        have_old_q <= have_old_nx;
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= req_i.light_id;
      now_q <= req_i.frame_now;
    end
    if ((state_q == ST_SCAN) && eval_vld_q) begin
      old_idx_q   <= old_idx_nx;
      old_frame_q <= old_frame_nx;
      if (hit_keep || hit_take) begin
        found_q <= 1'b1;
        pick_q  <= eval_idx_q;
        rej_q   <= !hit_keep;
      end else if (last_slot) begin
        found_q <= have_old_nx;
        pick_q  <= have_old_nx ? old_idx_nx : '0;
        rej_q   <= have_old_nx;
      end
    end
  end

  assign pick_ext = 32'(pick_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q.found          <= found_q;
      rsp_q.slot_index     <= pick_ext[SlotIdxW-1:0];
      rsp_q.reject_history <= rej_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[design/fssa_checker.sv]
// Port-level checker for the frame-stamped slot allocator, with its bind.
// Depends on fssa_pkg and frame_stamped_slot_allocator.
module fssa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_stall_o,
  input logic                rsp_valid_o,
  input logic                rsp_stall_i,
  input fssa_pkg::fssa_rsp_t rsp_o
);
  import fssa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("request taken while previous still in progress");

  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(req_stall_o))
    else $error("response without a request in progress");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.found |-> rsp_o.slot_index == '0 && !rsp_o.reject_history)
    else $error("not-found response carries nonzero fields");

endmodule

bind frame_stamped_slot_allocator fssa_checker u_fssa_checker (.*);
